// ===== design/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash probe table package
// Shared sizes, action and status codes, and the transfer and entry types
// used by the probing hash table and its node pool.
// ----------------------------------------------------------------------------
package hpt_pkg;

  // Table geometry. TABLE_SIZE is a power of two, so the home slot of a key
  // is its low SLOT_W bits.
  localparam int TABLE_SIZE = 256;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int NODE_W     = 8;
  localparam int KEY_W      = 16;
  localparam int DATA_W     = 16;

  // Head value that marks a slot as empty, and the null link.
  localparam logic [NODE_W-1:0] EMPTY_NODE = '0;

  // Action codes.
  localparam logic [1:0] ACT_GET   = 2'd0;
  localparam logic [1:0] ACT_INS   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
  localparam logic [1:0] STAT_POOL_EMPTY = 2'd3;

  // Input transfer.
  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] item_data;
    logic [NODE_W-1:0] node_index;
  } hpt_in_t;

  // Result transfer.
  typedef struct packed {
    logic [NODE_W-1:0] head_node;
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] node_data;
    logic [1:0]        status;
  } hpt_out_t;

  // One table slot: its key and the head of its node list.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] head;
  } slot_entry_t;

  // Verdict of the probe unit on the slot that was just read.
  typedef struct packed {
    logic              empty;
    logic              hit;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] next_slot;
  } probe_stat_t;

endpackage

// ===== design/hpt_ram.sv =====
// ----------------------------------------------------------------------------
// Hash probe table RAM
// Generic single-port-write, single-port-read memory with registered read
// data.
// ----------------------------------------------------------------------------
module hpt_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hpt_probe_unit.sv =====
// ----------------------------------------------------------------------------
// Hash probe table probe unit
// Holds the current probe slot and probe count, compares the slot just read
// against the search key and forms the next slot with wrap-around.
// ----------------------------------------------------------------------------
module hpt_probe_unit
  import hpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [SLOT_W-1:0] home,
  input  logic              step,
  input  logic [KEY_W-1:0]  key,
  input  slot_entry_t       entry,
  output probe_stat_t       stat
);

  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [SLOT_W-1:0] cnt_r;
  logic [SLOT_W-1:0] cnt_nxt;
  logic [SLOT_W-1:0] inc_slot;

  // Next slot in probe order, wrapping to slot 0.
  assign inc_slot = (slot_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : slot_r + 1'b1;

  // Compare the slot read for this probe.
  always_comb begin
    stat.empty     = (entry.head == EMPTY_NODE);
    stat.hit       = (entry.head != EMPTY_NODE) && (entry.key == key);
    stat.last      = (cnt_r == SLOT_W'(TABLE_SIZE - 1));
    stat.slot      = slot_r;
    stat.next_slot = inc_slot;
  end

  // Probe position update.
  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = home;
      cnt_nxt  = '0;
    end else if (step) begin
      slot_nxt = inc_slot;
      cnt_nxt  = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      cnt_r  <= '0;
    end else begin
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== design/probing_hash_table_with_node_pool.sv =====
// ----------------------------------------------------------------------------
// Probing hash table with node pool
// Linear-probing table of keys and list heads, backed by a pool of linked
// data nodes that insert hands out from the top down.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot, link and data stores to zero, one
// entry per cycle, and holds busy high until the sweep is done. A transfer
// is accepted on a clock edge where start is high and busy is low. Get and
// insert keep busy high while they probe; each probe is one read of the slot
// memory checked by the shared probe unit, and the result strobe is
// registered in the cycle after the last probe. Read node keeps busy for one
// cycle; its result is taken from the registered read data of the node
// stores and then registered onto out_result. Write node and an insert into
// an empty pool finish at once: the result appears in the next cycle and busy
// never rises. Each result is on out_result for a single cycle with out_valid
// high and cannot be stalled, so the receiver must take it in that cycle.
// ----------------------------------------------------------------------------
module probing_hash_table_with_node_pool
  import hpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hpt_in_t  in_item,
  output logic     out_valid,
  output hpt_out_t out_result
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_NODE
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NODE_W-1:0] free_ptr_r, free_ptr_nxt;
  hpt_in_t           req_r, req_nxt;
  hpt_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Memory port controls.
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  slot_entry_t       slot_wdata;
  logic [SLOT_W-1:0] slot_raddr;
  slot_entry_t       slot_rdata;
  logic              link_we;
  logic [NODE_W-1:0] link_waddr;
  logic [NODE_W-1:0] link_wdata;
  logic [NODE_W-1:0] link_rdata;
  logic              val_we;
  logic [NODE_W-1:0] val_waddr;
  logic [DATA_W-1:0] val_wdata;
  logic [DATA_W-1:0] val_rdata;
  logic [NODE_W-1:0] node_raddr;

  // Probe unit controls.
  logic              probe_load;
  logic              probe_step;
  probe_stat_t       stat;
  logic              node_ok;

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // A node index beyond the pool is answered as not found.
  assign node_ok = ({1'b0, in_item.node_index} < (NODE_W + 1)'(TABLE_SIZE));

  // Slot store: key and list head of each slot.
  hpt_ram #(
    .WIDTH  ($bits(slot_entry_t)),
    .ADDR_W (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Node link store.
  hpt_ram #(
    .WIDTH  (NODE_W),
    .ADDR_W (NODE_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (node_raddr),
    .rdata (link_rdata)
  );

  // Node data store.
  hpt_ram #(
    .WIDTH  (DATA_W),
    .ADDR_W (NODE_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (node_raddr),
    .rdata (val_rdata)
  );

  // Shared probe compare and step unit.
  hpt_probe_unit u_probe (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (probe_load),
    .home  (in_item.key[SLOT_W-1:0]),
    .step  (probe_step),
    .key   (req_r.key),
    .entry (slot_rdata),
    .stat  (stat)
  );

  // Sequencer next-state and memory control.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    free_ptr_nxt  = free_ptr_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    slot_we    = 1'b0;
    slot_waddr = stat.slot;
    slot_wdata = '{key: req_r.key, head: free_ptr_r};
    slot_raddr = stat.next_slot;
    link_we    = 1'b0;
    link_waddr = free_ptr_r;
    link_wdata = slot_rdata.head;
    val_we     = 1'b0;
    val_waddr  = free_ptr_r;
    val_wdata  = req_r.item_data;
    node_raddr = in_item.node_index;
    probe_load = 1'b0;
    probe_step = 1'b0;

    case (state_r)
      // Sweep every store to zero after reset.
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt_r;
        slot_wdata = '0;
        link_we    = 1'b1;
        link_waddr = NODE_W'(clr_cnt_r);
        link_wdata = '0;
        val_we     = 1'b1;
        val_waddr  = NODE_W'(clr_cnt_r);
        val_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_W'(TABLE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Accept a transfer and start its work.
      ST_IDLE: begin
        slot_raddr = in_item.key[SLOT_W-1:0];
        if (start) begin
          req_nxt = in_item;
          out_nxt = '0;
          case (in_item.action)
            ACT_GET: begin
              probe_load = 1'b1;
              state_nxt  = ST_PROBE;
            end
            ACT_INS: begin
              if (free_ptr_r == EMPTY_NODE) begin
                out_nxt.status = STAT_POOL_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                probe_load = 1'b1;
                state_nxt  = ST_PROBE;
              end
            end
            ACT_READ: begin
              if (node_ok) begin
                state_nxt = ST_NODE;
              end else begin
                out_nxt.status = STAT_NOT_FOUND;
                out_valid_nxt  = 1'b1;
              end
            end
            ACT_WRITE: begin
              if (node_ok) begin
                val_we    = 1'b1;
                val_waddr = in_item.node_index;
                val_wdata = in_item.item_data;
              end else begin
                out_nxt.status = STAT_NOT_FOUND;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // One slot checked per cycle; the next slot read is issued meanwhile.
      ST_PROBE: begin
        if (stat.hit || stat.empty) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (req_r.action == ACT_INS) begin
            // Link a fresh pool node in as the new list head.
            slot_we      = 1'b1;
            link_we      = 1'b1;
            val_we       = 1'b1;
            free_ptr_nxt = free_ptr_r - 1'b1;
            out_nxt.head_node  = free_ptr_r;
            out_nxt.slot_index = stat.slot;
            out_nxt.status     = STAT_OK;
          end else if (stat.hit) begin
            out_nxt.head_node  = slot_rdata.head;
            out_nxt.slot_index = stat.slot;
            out_nxt.status     = STAT_OK;
          end else begin
            out_nxt.status = STAT_NOT_FOUND;
          end
        end else if (stat.last) begin
          out_nxt.status = STAT_TABLE_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          probe_step = 1'b1;
        end
      end

      // Node read data has arrived.
      ST_NODE: begin
        out_nxt.head_node = link_rdata;
        out_nxt.node_data = val_rdata;
        out_nxt.status    = STAT_OK;
        out_valid_nxt     = 1'b1;
        state_nxt         = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      free_ptr_r  <= NODE_W'(TABLE_SIZE - 1);
      out_valid_r <= 1'b0;
      req_r       <= '0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_ptr_r  <= free_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      req_r       <= req_nxt;
      out_r       <= out_nxt;
    end
  end

endmodule

// ===== tb/table_op_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table result checker
// Watches the command and result channels of the probing hash table. Each
// accepted command is run through a cycle-free model of the slot table and
// node pool, and each result strobe is compared field by field with the
// oldest predicted answer.
// ----------------------------------------------------------------------------
module table_op_checker
  import hpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  hpt_in_t  in_item,
  input  logic     out_valid,
  input  hpt_out_t out_result,
  output int       fail_count,
  output int       answers_left
);

  // Outcome of a linear probe for one key.
  typedef enum logic [1:0] {
    PROBE_HIT,
    PROBE_EMPTY,
    PROBE_FULL
  } probe_outcome_t;

  // Model copy of the slot table and the node pool.
  logic [KEY_W-1:0]  tab_key   [TABLE_SIZE];
  logic [NODE_W-1:0] tab_head  [TABLE_SIZE];
  logic [NODE_W-1:0] pool_link [TABLE_SIZE];
  logic [DATA_W-1:0] pool_data [TABLE_SIZE];
  logic [NODE_W-1:0] next_free;

  // Answers still owed by the block, oldest first.
  hpt_out_t answers_due[$];

  // Walk from the home slot until the key, an empty slot, or a full lap.
  function automatic probe_outcome_t find_slot(input logic [KEY_W-1:0] key,
                                               output int slot);
    int s;
    s = int'(key) % TABLE_SIZE;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (tab_head[s] == EMPTY_NODE) begin
        slot = s;
        return PROBE_EMPTY;
      end
      if (tab_key[s] == key) begin
        slot = s;
        return PROBE_HIT;
      end
      s = (s + 1) % TABLE_SIZE;
    end
    slot = 0;
    return PROBE_FULL;
  endfunction

  // Apply one command to the model and return the answer it should give.
  function automatic hpt_out_t apply_table_op(input hpt_in_t op);
    hpt_out_t answer;
    probe_outcome_t found;
    int slot;
    answer = '0;
    case (op.action)
      ACT_GET: begin
        found = find_slot(op.key, slot);
        if (found == PROBE_HIT) begin
          answer.head_node  = tab_head[slot];
          answer.slot_index = SLOT_W'(slot);
        end else begin
          answer.status = (found == PROBE_EMPTY) ? STAT_NOT_FOUND : STAT_TABLE_FULL;
        end
      end
      ACT_INS: begin
        // An exhausted pool is reported before any probing happens.
        if (next_free == EMPTY_NODE) begin
          answer.status = STAT_POOL_EMPTY;
        end else begin
          found = find_slot(op.key, slot);
          if (found == PROBE_FULL) begin
            answer.status = STAT_TABLE_FULL;
          end else begin
            tab_key[slot]        = op.key;
            pool_data[next_free] = op.item_data;
            pool_link[next_free] = tab_head[slot];
            tab_head[slot]       = next_free;
            answer.head_node     = next_free;
            answer.slot_index    = SLOT_W'(slot);
            next_free            = next_free - 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (int'(op.node_index) < TABLE_SIZE) begin
          answer.head_node = pool_link[op.node_index];
          answer.node_data = pool_data[op.node_index];
        end else begin
          answer.status = STAT_NOT_FOUND;
        end
      end
      ACT_WRITE: begin
        if (int'(op.node_index) < TABLE_SIZE) begin
          pool_data[op.node_index] = op.item_data;
        end else begin
          answer.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        answer = '0;
      end
    endcase
    return answer;
  endfunction

  // Compare one result field; X or Z on the port counts as a mismatch.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Results are checked before the command of the same edge is modeled,
  // since a result always belongs to an earlier transfer.
  always @(posedge clk) begin : watch
    hpt_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        tab_key[i]   = '0;
        tab_head[i]  = EMPTY_NODE;
        pool_link[i] = EMPTY_NODE;
        pool_data[i] = '0;
      end
      next_free = NODE_W'(TABLE_SIZE - 1);
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          $error("result with no command outstanding: head_node 0x%0h status %0d",
                 out_result.head_node, out_result.status);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          check_field("head_node", 32'(want.head_node), 32'(out_result.head_node));
          check_field("slot_index", 32'(want.slot_index), 32'(out_result.slot_index));
          check_field("node_data", 32'(want.node_data), 32'(out_result.node_data));
          check_field("status", 32'(want.status), 32'(out_result.status));
        end
      end
      if (start && !busy) begin
        answers_due.push_back(apply_table_op(in_item));
      end
    end
    answers_left <= answers_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing hash table testbench
// Drives get, insert, read node and write node commands into the hash table:
// a directed opening on an empty table, then random traffic built around
// colliding and repeated keys, and finally enough inserts to drain the node
// pool. Commands come in bursts with random gaps. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import hpt_pkg::*;

  localparam int RUN_ITEMS    = 1100;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int POOL_NODES   = TABLE_SIZE - 1;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  hpt_in_t  in_item;
  logic     out_valid;
  hpt_out_t out_result;

  int fail_count;
  int answers_left;
  int cycles       = 0;
  int items_sent   = 0;
  int inserts_sent = 0;
  int burst_left   = 0;

  // Recently inserted keys, reused so that gets hit and lists grow.
  logic [KEY_W-1:0] known_keys[$];

  always #5 clk = ~clk;

  probing_hash_table_with_node_pool DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  table_op_checker op_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .fail_count   (fail_count),
    .answers_left (answers_left)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic hpt_in_t make_op(input logic [1:0] act,
                                      input logic [KEY_W-1:0] key,
                                      input logic [DATA_W-1:0] data,
                                      input logic [NODE_W-1:0] node);
    hpt_in_t op;
    op.action     = act;
    op.key        = key;
    op.item_data  = data;
    op.node_index = node;
    return op;
  endfunction

  // Mostly keys already in the table or keys whose home slots cluster
  // around the wrap point; the rest are fully random.
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    logic [7:0] low;
    roll = $urandom_range(0, 99);
    if (roll < 45 && known_keys.size() > 0) begin
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    end
    if (roll < 75) begin
      low = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                        : 8'(8'hF8 + $urandom_range(0, 7));
      return {8'($urandom_range(0, 15)), low};
    end
    return KEY_W'($urandom());
  endfunction

  // Nodes already handed out by the pool are favored, so reads walk lists.
  function automatic logic [NODE_W-1:0] pick_node();
    int handed;
    handed = (inserts_sent < POOL_NODES) ? inserts_sent : POOL_NODES;
    if (handed > 0 && $urandom_range(0, 99) < 70) begin
      return NODE_W'(TABLE_SIZE - 1 - int'($urandom_range(0, handed - 1)));
    end
    return NODE_W'($urandom_range(0, TABLE_SIZE - 1));
  endfunction

  // Open a gap between bursts; a quarter of the bursts follow without one.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Hold the command until the block takes it in a transfer.
  task automatic send_op(input hpt_in_t op);
    start   <= 1'b1;
    in_item <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (op.action == ACT_INS) begin
      inserts_sent++;
      known_keys.push_back(op.key);
      if (known_keys.size() > 48) void'(known_keys.pop_front());
    end
  endtask

  task automatic send_paced(input hpt_in_t op);
    pace_sender();
    send_op(op);
  endtask

  initial begin
    int roll;
    logic [1:0] act;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening on an empty table: absent keys, node 0 and the top
    // node, key extremes, a probe that wraps past the last slot, a key that
    // gains a second node, and list walking by node reads.
    send_paced(make_op(ACT_GET,   16'h0000, 16'h0000, 8'h00));
    send_paced(make_op(ACT_READ,  16'hFFFF, 16'hFFFF, 8'h00));
    send_paced(make_op(ACT_READ,  16'h0000, 16'h0000, 8'hFF));
    send_paced(make_op(ACT_WRITE, 16'h0000, 16'hFFFF, 8'h00));
    send_paced(make_op(ACT_READ,  16'h0000, 16'h0000, 8'h00));
    send_paced(make_op(ACT_INS,   16'h0000, 16'hFFFF, 8'h00));
    send_paced(make_op(ACT_INS,   16'hFFFF, 16'h0000, 8'hFF));
    send_paced(make_op(ACT_INS,   16'h01FF, 16'hA5A5, 8'h55));
    send_paced(make_op(ACT_INS,   16'h0000, 16'h1234, 8'hAA));
    send_paced(make_op(ACT_GET,   16'h0000, 16'h0000, 8'h00));
    send_paced(make_op(ACT_GET,   16'h01FF, 16'h0000, 8'h00));
    send_paced(make_op(ACT_GET,   16'h02FF, 16'h0000, 8'h00));
    send_paced(make_op(ACT_READ,  16'h0000, 16'h0000, 8'hFC));
    send_paced(make_op(ACT_READ,  16'h0000, 16'h0000, 8'hFF));
    send_paced(make_op(ACT_WRITE, 16'hFFFF, 16'h5A5A, 8'hFF));
    send_paced(make_op(ACT_READ,  16'h0000, 16'h0000, 8'hFF));
    send_paced(make_op(ACT_WRITE, 16'h0000, 16'h0000, 8'hFE));
    send_paced(make_op(ACT_GET,   16'hFFFF, 16'hFFFF, 8'hFF));
    send_paced(make_op(ACT_INS,   16'h0100, 16'h8001, 8'h01));
    send_paced(make_op(ACT_GET,   16'h0100, 16'h0000, 8'h00));
    send_paced(make_op(ACT_READ,  16'h0000, 16'h0000, 8'hFB));

    // Random traffic with a mix close to a working list store.
    while (items_sent < RUN_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 24) act = ACT_INS;
      else if (roll < 58) act = ACT_GET;
      else if (roll < 82) act = ACT_READ;
      else act = ACT_WRITE;
      send_paced(make_op(act, pick_key(), DATA_W'($urandom()), pick_node()));
    end

    // Drain the pool so that inserts meet an empty pool.
    while (inserts_sent < POOL_NODES + 10) begin
      send_paced(make_op(ACT_INS, pick_key(), DATA_W'($urandom()), pick_node()));
    end

    start <= 1'b0;
    @(posedge clk);
    while (answers_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hpt_pkg.sv
design/hpt_ram.sv
design/hpt_probe_unit.sv
design/probing_hash_table_with_node_pool.sv
tb/table_op_checker.sv
tb/testbench.sv
